// ===== hw/rtl/pcaw_pkg.sv =====
// ---------------------------------------------------------------------------
// PCA projection package
// Shared types, codes and helpers for the PCA projection/whitening block.
// ---------------------------------------------------------------------------
`default_nettype none

package pcaw_pkg;

   // Table geometry, fixed by the widths of the item fields
   localparam int MAX_FEATURES   = 16;
   localparam int MAX_COMPONENTS = 8;
   localparam int FI_W           = 4;
   localparam int CI_W           = 3;

   // Item function codes
   localparam logic [1:0] FUNC_MEAN   = 2'd0;
   localparam logic [1:0] FUNC_COEF   = 2'd1;
   localparam logic [1:0] FUNC_SCALE  = 2'd2;
   localparam logic [1:0] FUNC_SAMPLE = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_WHITEN = 2'd0;
   localparam logic [1:0] CSR_USED   = 2'd1;
   localparam logic [1:0] CSR_READY  = 2'd2;

   // Sequencer states
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CENTER = 8'b0000_0010,
      ST_MAC    = 8'b0000_0100,
      ST_DRAIN  = 8'b0000_1000,
      ST_FRD    = 8'b0001_0000,
      ST_FCALC  = 8'b0010_0000,
      ST_DIV    = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   // Saturate a sign/magnitude pair to a signed 32-bit word
   function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
      logic [63:0] m;
      begin
         m = mag;
         if (neg) begin
            if (m > 64'h0000_0000_8000_0000) m = 64'h0000_0000_8000_0000;
            sat32 = 32'(64'd0 - m);
         end else begin
            if (m > 64'h0000_0000_7FFF_FFFF) m = 64'h0000_0000_7FFF_FFFF;
            sat32 = m[31:0];
         end
      end
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pcaw_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module pcaw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pca_projection_whiten_top.sv =====
// ---------------------------------------------------------------------------
// PCA projection with whitening
// Centers each sample feature by its mean and accumulates it into one
// accumulator per component; on the last feature emits one result per used
// component, optionally divided by its singular value (one error if not ready).
// ---------------------------------------------------------------------------
// A table-load item is written as it is taken; a sample feature runs
// through mean read, centering, one multiply-accumulate issue per component
// through the shared multiplier, and a pipeline drain. On a last feature each
// result is read and finished, through the 32-step restoring divider
// (whitening on, positive scale, quotient in range), then waits for output.
// Reset clears control, config and accumulator valid bits (accumulators
// read as zero); mean, coefficient and scale tables are undefined until written.
`default_nettype none

module pca_projection_whiten_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [3:0]  req_feature_index,
   input  wire logic [2:0]  req_component_index,
   input  wire logic [31:0] req_data_value,
   input  wire logic        req_last_feature,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_projection,
   output logic [2:0]       rsp_component_number,
   output logic             rsp_last_of_run,
   output logic             rsp_not_fitted,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int KW = pcaw_pkg::CI_W;
   localparam int FW = pcaw_pkg::FI_W;

   pcaw_pkg::state_type state_ff, state_in;

   logic              whiten_ff, whiten_in;
   logic [3:0]        cu_ff, cu_in;
   logic              mready_ff, mready_in;

   logic [KW-1:0]     k_ff, k_in;
   logic [FW-1:0]     fi_ff, fi_in;
   logic [31:0]       feat_ff, feat_in;
   logic              last_ff, last_in;
   logic [32:0]       centred_ff, centred_in;

   logic              s1_vld_ff, s1_vld_in, s2_vld_ff, s2_vld_in;
   logic [KW-1:0]     s1_k_ff, s1_k_in, s2_k_ff, s2_k_in;
   logic [63:0]       prod_ff, prod_in;
   logic [63:0]       acc1_ff, acc1_in;
   logic [pcaw_pkg::MAX_COMPONENTS-1:0] accv_ff, accv_in;

   logic              neg_ff, neg_in;
   logic [31:0]       scl_ff, scl_in;
   logic [31:0]       rem_ff, rem_in;
   logic [31:0]       dsh_ff, dsh_in;
   logic [31:0]       quo_ff, quo_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [31:0]       res_ff, res_in;
   logic              err_ff, err_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_proj_ff, rsp_proj_in;
   logic [KW-1:0]     rsp_comp_ff, rsp_comp_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_nf_ff, rsp_nf_in;

   logic              in_acc, cfg_acc;
   logic [31:0]       mean_rd, coef_rd, scale_rd;
   logic [63:0]       acc_rd;
   logic              acc_rd_en, acc_wr_en;
   logic [64:0]       prod_full;
   logic [63:0]       acc_sum;
   logic [3:0]        used;
   logic              last_comp;
   logic [63:0]       facc, fmag;
   logic              fwhite;
   logic [32:0]       dtrial;
   logic              qbit;
   logic [31:0]       quo_next;

   assign in_acc    = req_valid && req_ready;
   assign cfg_acc   = csr_valid && csr_ready;
   assign req_ready = (state_ff == pcaw_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // Table memories and accumulator memory
   pcaw_ram #(.WIDTH(32), .DEPTH(pcaw_pkg::MAX_FEATURES)) u_mean (
      .clock(clock),
      .wr_en(in_acc && req_func == pcaw_pkg::FUNC_MEAN),
      .wr_addr(req_feature_index), .wr_data(req_data_value),
      .rd_en(in_acc && req_func == pcaw_pkg::FUNC_SAMPLE),
      .rd_addr(req_feature_index), .rd_data(mean_rd)
   );

   pcaw_ram #(.WIDTH(32), .DEPTH(pcaw_pkg::MAX_FEATURES * pcaw_pkg::MAX_COMPONENTS)) u_coef (
      .clock(clock),
      .wr_en(in_acc && req_func == pcaw_pkg::FUNC_COEF),
      .wr_addr({req_component_index, req_feature_index}), .wr_data(req_data_value),
      .rd_en(state_ff == pcaw_pkg::ST_MAC),
      .rd_addr({k_ff, fi_ff}), .rd_data(coef_rd)
   );

   pcaw_ram #(.WIDTH(32), .DEPTH(pcaw_pkg::MAX_COMPONENTS)) u_scale (
      .clock(clock),
      .wr_en(in_acc && req_func == pcaw_pkg::FUNC_SCALE),
      .wr_addr(req_component_index), .wr_data(req_data_value),
      .rd_en(state_ff == pcaw_pkg::ST_FRD),
      .rd_addr(k_ff), .rd_data(scale_rd)
   );

   assign acc_rd_en = (state_ff == pcaw_pkg::ST_MAC) || (state_ff == pcaw_pkg::ST_FRD);
   assign acc_wr_en = s2_vld_ff;

   pcaw_ram #(.WIDTH(64), .DEPTH(pcaw_pkg::MAX_COMPONENTS)) u_acc (
      .clock(clock),
      .wr_en(acc_wr_en), .wr_addr(s2_k_ff), .wr_data(acc_sum),
      .rd_en(acc_rd_en), .rd_addr(k_ff), .rd_data(acc_rd)
   );

   // Multiply, then shift and accumulate one stage later
   assign prod_full = $signed(centred_ff) * $signed(coef_rd);
   assign acc_sum   = acc1_ff + {{16{prod_ff[63]}}, prod_ff[63:16]};

   // Clamp the component count
   always_comb begin
      if (cu_ff == 4'd0)
         used = 4'd1;
      else if (cu_ff > 4'(pcaw_pkg::MAX_COMPONENTS))
         used = 4'(pcaw_pkg::MAX_COMPONENTS);
      else
         used = cu_ff;
   end
   assign last_comp = ({1'b0, k_ff} == (used - 4'd1));

   // Finish operands and divider step
   assign facc     = accv_ff[k_ff] ? acc_rd : 64'd0;
   assign fmag     = facc[63] ? (64'd0 - facc) : facc;
   assign fwhite   = whiten_ff && (scale_rd != 32'd0) && !scale_rd[31];
   assign dtrial   = {rem_ff, dsh_ff[31]};
   assign qbit     = (dtrial >= {1'b0, scl_ff});
   assign quo_next = {quo_ff[30:0], qbit};

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      whiten_in    = whiten_ff;
      cu_in        = cu_ff;
      mready_in    = mready_ff;
      k_in         = k_ff;
      fi_in        = fi_ff;
      feat_in      = feat_ff;
      last_in      = last_ff;
      centred_in   = centred_ff;
      accv_in      = accv_ff;
      neg_in       = neg_ff;
      scl_in       = scl_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_proj_in  = rsp_proj_ff;
      rsp_comp_in  = rsp_comp_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_nf_in    = rsp_nf_ff;

      // pipeline stages follow the issue slot
      s1_vld_in = (state_ff == pcaw_pkg::ST_MAC);
      s1_k_in   = k_ff;
      s2_vld_in = s1_vld_ff;
      s2_k_in   = s1_k_ff;
      prod_in   = prod_full[63:0];
      acc1_in   = accv_ff[s1_k_ff] ? acc_rd : 64'd0;
      if (s2_vld_ff) accv_in[s2_k_ff] = 1'b1;

      // drop the shown result once taken
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      // configuration writes
      if (cfg_acc) begin
         case (csr_index)
            pcaw_pkg::CSR_WHITEN: whiten_in = csr_data[0];
            pcaw_pkg::CSR_USED:   cu_in     = csr_data[3:0];
            pcaw_pkg::CSR_READY:  mready_in = csr_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         pcaw_pkg::ST_IDLE: begin
            if (in_acc && req_func == pcaw_pkg::FUNC_SAMPLE) begin
               fi_in    = req_feature_index;
               feat_in  = req_data_value;
               last_in  = req_last_feature;
               state_in = pcaw_pkg::ST_CENTER;
            end
         end
         pcaw_pkg::ST_CENTER: begin
            centred_in = {feat_ff[31], feat_ff} - {mean_rd[31], mean_rd};
            k_in       = '0;
            state_in   = pcaw_pkg::ST_MAC;
         end
         pcaw_pkg::ST_MAC: begin
            k_in = k_ff + 1'b1;
            if (k_ff == KW'(pcaw_pkg::MAX_COMPONENTS - 1)) state_in = pcaw_pkg::ST_DRAIN;
         end
         pcaw_pkg::ST_DRAIN: begin
            // hold until every accumulator write has landed
            if (!s1_vld_ff && !s2_vld_ff) begin
               k_in = '0;
               if (!last_ff) begin
                  state_in = pcaw_pkg::ST_IDLE;
               end else if (!mready_ff) begin
                  err_in   = 1'b1;
                  res_in   = 32'd0;
                  state_in = pcaw_pkg::ST_EMIT;
               end else begin
                  err_in   = 1'b0;
                  state_in = pcaw_pkg::ST_FRD;
               end
            end
         end
         pcaw_pkg::ST_FRD: begin
            state_in = pcaw_pkg::ST_FCALC;
         end
         pcaw_pkg::ST_FCALC: begin
            neg_in = facc[63];
            scl_in = scale_rd;
            if (!fwhite) begin
               res_in   = pcaw_pkg::sat32(facc[63], fmag);
               state_in = pcaw_pkg::ST_EMIT;
            end else if (fmag >= {16'd0, scale_rd, 16'd0}) begin
               res_in   = pcaw_pkg::sat32(facc[63], 64'hFFFF_FFFF_FFFF_FFFF);
               state_in = pcaw_pkg::ST_EMIT;
            end else begin
               rem_in   = fmag[47:16];
               dsh_in   = {fmag[15:0], 16'd0};
               quo_in   = 32'd0;
               cnt_in   = 5'd0;
               state_in = pcaw_pkg::ST_DIV;
            end
         end
         pcaw_pkg::ST_DIV: begin
            // one quotient bit per cycle
            rem_in = qbit ? 32'(dtrial - {1'b0, scl_ff}) : dtrial[31:0];
            dsh_in = {dsh_ff[30:0], 1'b0};
            quo_in = quo_next;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               res_in   = pcaw_pkg::sat32(neg_ff, {32'd0, quo_next});
               state_in = pcaw_pkg::ST_EMIT;
            end
         end
         pcaw_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_proj_in  = res_ff;
               rsp_comp_in  = err_ff ? '0 : k_ff;
               rsp_last_in  = err_ff || last_comp;
               rsp_nf_in    = err_ff;
               if (err_ff || last_comp) begin
                  accv_in  = '0;
                  state_in = pcaw_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = pcaw_pkg::ST_FRD;
               end
            end
         end
         default: state_in = pcaw_pkg::ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcaw_pkg::ST_IDLE;
         whiten_ff    <= 1'b0;
         cu_ff        <= 4'd8;
         mready_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         accv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         whiten_ff    <= whiten_in;
         cu_ff        <= cu_in;
         mready_ff    <= mready_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         accv_ff      <= accv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      fi_ff       <= fi_in;
      feat_ff     <= feat_in;
      last_ff     <= last_in;
      centred_ff  <= centred_in;
      s1_k_ff     <= s1_k_in;
      s2_k_ff     <= s2_k_in;
      prod_ff     <= prod_in;
      acc1_ff     <= acc1_in;
      neg_ff      <= neg_in;
      scl_ff      <= scl_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      err_ff      <= err_in;
      rsp_proj_ff <= rsp_proj_in;
      rsp_comp_ff <= rsp_comp_in;
      rsp_last_ff <= rsp_last_in;
      rsp_nf_ff   <= rsp_nf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_projection       = rsp_proj_ff;
   assign rsp_component_number = rsp_comp_ff;
   assign rsp_last_of_run      = rsp_last_ff;
   assign rsp_not_fitted       = rsp_nf_ff;

   // Checks
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!s1_vld_ff && !s2_vld_ff))
      else $error("pipeline busy while taking items");

   a_acc_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (acc_wr_en && acc_rd_en) |-> (s2_k_ff != k_ff))
      else $error("accumulator read and write hit one entry");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_nf_ff) |-> (rsp_last_ff && rsp_comp_ff == '0))
      else $error("error result malformed");

   a_clear_after_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcaw_pkg::ST_EMIT && (err_ff || last_comp) && (!rsp_valid_ff || rsp_ready))
      |=> (accv_ff == '0))
      else $error("accumulators not cleared after run");

endmodule

`default_nettype wire
